// File: rtl/core/bq_pkg.sv
// bq_pkg: shared constants for the biquad IIR filter
// default widths, coefficient formats and register indexes
// no dependencies
package bq_pkg;

   // default field widths
   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 32;

   // integer bits of the coefficient format (Q4.x)
   localparam int COEF_INT_BITS = 4;

   // register index port
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_COEF_B0       = 3'd0;
   localparam csr_index_type CSR_COEF_B1       = 3'd1;
   localparam csr_index_type CSR_COEF_B2       = 3'd2;
   localparam csr_index_type CSR_COEF_A1       = 3'd3;
   localparam csr_index_type CSR_COEF_A2       = 3'd4;
   localparam csr_index_type CSR_FILTER_ENABLE = 3'd5;

endpackage

// File: rtl/core/bq_mac.sv
// bq_mac: five-tap multiply-accumulate of the biquad with rounding and saturation
// purely combinational; sits between the input register and the result register
// depends on bq_pkg
module bq_mac #(
   parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = bq_pkg::COEF_WIDTH_DEF
) (
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic signed [SAMPLE_WIDTH-1:0] x1,
   input  logic signed [SAMPLE_WIDTH-1:0] x2,
   input  logic signed [SAMPLE_WIDTH-1:0] y1,
   input  logic signed [SAMPLE_WIDTH-1:0] y2,
   input  logic signed [COEF_WIDTH-1:0]   coef_b0,
   input  logic signed [COEF_WIDTH-1:0]   coef_b1,
   input  logic signed [COEF_WIDTH-1:0]   coef_b2,
   input  logic signed [COEF_WIDTH-1:0]   coef_a1,
   input  logic signed [COEF_WIDTH-1:0]   coef_a2,
   output logic signed [SAMPLE_WIDTH-1:0] result
);
   import bq_pkg::*;

   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;
   localparam int FRAC_SHIFT = COEF_WIDTH - COEF_INT_BITS;
   localparam int Y_WIDTH    = ACC_WIDTH - FRAC_SHIFT;

   // half an output lsb, for round half up
   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
      {{(ACC_WIDTH-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};
   localparam logic signed [Y_WIDTH-1:0] Y_MAX =
      {{(Y_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [Y_WIDTH-1:0] Y_MIN =
      {{(Y_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [PROD_WIDTH-1:0] prod_b0;
   logic signed [PROD_WIDTH-1:0] prod_b1;
   logic signed [PROD_WIDTH-1:0] prod_b2;
   logic signed [PROD_WIDTH-1:0] prod_a1;
   logic signed [PROD_WIDTH-1:0] prod_a2;
   logic signed [ACC_WIDTH-1:0]  acc;
   logic signed [ACC_WIDTH-1:0]  acc_rnd;
   logic signed [Y_WIDTH-1:0]    y_wide;

   // five independent products
   assign prod_b0 = coef_b0 * sample;
   assign prod_b1 = coef_b1 * x1;
   assign prod_b2 = coef_b2 * x2;
   assign prod_a1 = coef_a1 * y1;
   assign prod_a2 = coef_a2 * y2;

   // exact sum, feedback terms subtracted
   assign acc = ACC_WIDTH'(prod_b0) + ACC_WIDTH'(prod_b1) + ACC_WIDTH'(prod_b2)
              - ACC_WIDTH'(prod_a1) - ACC_WIDTH'(prod_a2);

   // round and drop the fraction (floor of the biased sum)
   assign acc_rnd = acc + ROUND_BIAS;
   assign y_wide  = acc_rnd[ACC_WIDTH-1:FRAC_SHIFT];

   // saturate to the sample range
   always_comb begin
      if (y_wide > Y_MAX) begin
         result = Y_MAX[SAMPLE_WIDTH-1:0];
      end else if (y_wide < Y_MIN) begin
         result = Y_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         result = y_wide[SAMPLE_WIDTH-1:0];
      end
   end

endmodule

// File: rtl/core/biquad_iir_filter_top.sv
// biquad_iir_filter_top: Direct Form I biquad with coefficient registers
// path: an accepted item sits in the input register, then moves into the result
// register, where rsp_valid rises; rsp_stall can hold it in the input register
// throughput: one item per cycle while rsp_stall does not hold the result register;
// the a1 feedback loop (multiply, sum, round, saturate) holds only the y1 register
// reset: history cleared, b0 = 1.0, other coefficients zero, filter enabled
// depends on bq_pkg and bq_mac
module biquad_iir_filter_top #(
   parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = bq_pkg::COEF_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_in,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_sample_out,
   // register write port
   input  logic                               csr_write_enable,
   input  bq_pkg::csr_index_type              csr_index,
   input  logic [COEF_WIDTH-1:0]              csr_write_data
);
   import bq_pkg::*;

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
      {{COEF_INT_BITS{1'b0}}, {(COEF_WIDTH-COEF_INT_BITS){1'b0}}}
      | (COEF_WIDTH'(1) << (COEF_WIDTH - COEF_INT_BITS));

   // coefficient registers
   logic signed [COEF_WIDTH-1:0] coef_b0_ff, coef_b0_in;
   logic signed [COEF_WIDTH-1:0] coef_b1_ff, coef_b1_in;
   logic signed [COEF_WIDTH-1:0] coef_b2_ff, coef_b2_in;
   logic signed [COEF_WIDTH-1:0] coef_a1_ff, coef_a1_in;
   logic signed [COEF_WIDTH-1:0] coef_a2_ff, coef_a2_in;
   logic                         filter_enable_ff, filter_enable_in;

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff, in_sample_in;

   // history
   logic signed [SAMPLE_WIDTH-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_WIDTH-1:0] x2_ff, x2_in;
   logic signed [SAMPLE_WIDTH-1:0] y1_ff, y1_in;
   logic signed [SAMPLE_WIDTH-1:0] y2_ff, y2_in;

   // result register
   logic                           out_valid_ff, out_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;

   logic                           out_free;
   logic                           advance;
   logic                           req_take;
   logic signed [SAMPLE_WIDTH-1:0] filtered;

   // register writes
   always_comb begin
      coef_b0_in       = coef_b0_ff;
      coef_b1_in       = coef_b1_ff;
      coef_b2_in       = coef_b2_ff;
      coef_a1_in       = coef_a1_ff;
      coef_a2_in       = coef_a2_ff;
      filter_enable_in = filter_enable_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COEF_B0:       coef_b0_in       = csr_write_data;
            CSR_COEF_B1:       coef_b1_in       = csr_write_data;
            CSR_COEF_B2:       coef_b2_in       = csr_write_data;
            CSR_COEF_A1:       coef_a1_in       = csr_write_data;
            CSR_COEF_A2:       coef_a2_in       = csr_write_data;
            CSR_FILTER_ENABLE: filter_enable_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // handshake: the result register frees up when empty or being taken
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // filter datapath
   bq_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_mac (
      .sample  (in_sample_ff),
      .x1      (x1_ff),
      .x2      (x2_ff),
      .y1      (y1_ff),
      .y2      (y2_ff),
      .coef_b0 (coef_b0_ff),
      .coef_b1 (coef_b1_ff),
      .coef_b2 (coef_b2_ff),
      .coef_a1 (coef_a1_ff),
      .coef_a2 (coef_a2_ff),
      .result  (filtered)
   );

   // next values of the pipeline and history
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_sample_in  = in_sample_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      x1_in         = x1_ff;
      x2_in         = x2_ff;
      y1_in         = y1_ff;
      y2_in         = y2_ff;

      // input register
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_sample_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // result register
      if (advance) begin
         out_valid_in = 1'b1;
         if (filter_enable_ff) begin
            out_sample_in = filtered;
            x2_in         = x1_ff;
            x1_in         = in_sample_ff;
            y2_in         = y1_ff;
            y1_in         = filtered;
         end else begin
            out_sample_in = in_sample_ff;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   // control state, history and coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff       <= COEF_ONE;
         coef_b1_ff       <= '0;
         coef_b2_ff       <= '0;
         coef_a1_ff       <= '0;
         coef_a2_ff       <= '0;
         filter_enable_ff <= 1'b1;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         x1_ff            <= '0;
         x2_ff            <= '0;
         y1_ff            <= '0;
         y2_ff            <= '0;
      end else begin
         coef_b0_ff       <= coef_b0_in;
         coef_b1_ff       <= coef_b1_in;
         coef_b2_ff       <= coef_b2_in;
         coef_a1_ff       <= coef_a1_in;
         coef_a2_ff       <= coef_a2_in;
         filter_enable_ff <= filter_enable_in;
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         x1_ff            <= x1_in;
         x2_ff            <= x2_in;
         y1_ff            <= y1_in;
         y2_ff            <= y2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_sample_ff  <= in_sample_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

endmodule

// File: sim/biquad_iir_filter_top_test.sv
`timescale 1ns / 100ps
// biquad_iir_filter_top_test: self-checking testbench for the biquad IIR filter
// an in-bench Direct Form I model predicts each output sample from the accepted items
// depends on bq_pkg and biquad_iir_filter_top
module biquad_iir_filter_top_test;

   import bq_pkg::*;

   localparam int SW   = SAMPLE_WIDTH_DEF;
   localparam int CW   = COEF_WIDTH_DEF;
   localparam int FRAC = CW - COEF_INT_BITS;

   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [CW-1:0] COEF_ONE  = 1 << FRAC;
   localparam logic [CW-1:0] COEF_HALF = 1 << (FRAC - 1);
   localparam logic [CW-1:0] COEF_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COEF_MIN  = {1'b1, {(CW-1){1'b0}}};

   // indexes that decode to no register
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [SW-1:0] req_sample_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [SW-1:0] rsp_sample_out;
   logic                 csr_write_enable;
   csr_index_type        csr_index;
   logic [CW-1:0]        csr_write_data;

   // filter model: coefficients, enable and history
   logic signed [CW-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
   logic                 filter_on;
   logic signed [SW-1:0] x_hist1, x_hist2, y_hist1, y_hist2;

   logic signed [SW-1:0] expected_samples[$];
   int                   mismatch_count;
   int                   cycle_count;
   int                   quiet_items;

   biquad_iir_filter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // reset state of the model
   task automatic model_reset();
      coef_b0   = COEF_ONE;
      coef_b1   = '0;
      coef_b2   = '0;
      coef_a1   = '0;
      coef_a2   = '0;
      filter_on = 1'b1;
      x_hist1   = '0;
      x_hist2   = '0;
      y_hist1   = '0;
      y_hist2   = '0;
   endtask

   // one filter step: exact sum, round half up, saturate, shift history; disabled: sample as is
   function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
      longint acc;
      longint y;
      if (!filter_on) return x;
      acc = longint'(coef_b0) * longint'(x)
          + longint'(coef_b1) * longint'(x_hist1)
          + longint'(coef_b2) * longint'(x_hist2)
          - longint'(coef_a1) * longint'(y_hist1)
          - longint'(coef_a2) * longint'(y_hist2);
      acc = acc + (longint'(1) <<< (FRAC - 1));
      y = acc >>> FRAC;
      if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
      if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
      x_hist2 = x_hist1;
      x_hist1 = x;
      y_hist2 = y_hist1;
      y_hist1 = y[SW-1:0];
      return y[SW-1:0];
   endfunction

   // send one item after a random gap, predict its result on acceptance
   task automatic send_sample(input logic signed [SW-1:0] value);
      int gap;
      if (quiet_items > 0) begin
         gap = 0;
         quiet_items--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 31) == 0) quiet_items = 40;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (req_stall);
      expected_samples.push_back(filter_sample(value));
   endtask

   // stop sending and wait for every expected item to arrive
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, mirrored into the model
   task automatic write_register(input csr_index_type index, input logic [CW-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      case (index)
         CSR_COEF_B0:       coef_b0 = data;
         CSR_COEF_B1:       coef_b1 = data;
         CSR_COEF_B2:       coef_b2 = data;
         CSR_COEF_A1:       coef_a1 = data;
         CSR_COEF_A2:       coef_a2 = data;
         CSR_FILTER_ENABLE: filter_on = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_coefs(input logic [CW-1:0] b0, b1, b2, a1, a2);
      write_register(CSR_COEF_B0, b0);
      write_register(CSR_COEF_B1, b1);
      write_register(CSR_COEF_B2, b2);
      write_register(CSR_COEF_A1, a1);
      write_register(CSR_COEF_A2, a2);
   endtask

   // coefficient: full range or a typical filter range of about +-2.0
   function automatic logic [CW-1:0] random_coef(input bit full_range);
      if (full_range) return $urandom();
      return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
   endfunction

   // sample: full range mostly, some small values and extremes
   function automatic logic signed [SW-1:0] random_sample();
      int r;
      logic [31:0] raw;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         raw = $urandom();
         return raw[SW-1:0];
      end
      if (r < 8) begin
         raw = $urandom_range(0, 2047) - 1024;
         return raw[SW-1:0];
      end
      case ($urandom_range(0, 3))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // check each output item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: output item with none expected, actual %0d", $time, rsp_sample_out);
            mismatch_count++;
         end else begin
            if (rsp_sample_out !== expected_samples[0]) begin
               $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                        $time, expected_samples[0], rsp_sample_out);
               mismatch_count++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   // receiver stall pattern, with occasional long open stretches
   initial begin : receiver_stall
      int stall_len;
      int open_len;
      rsp_stall = 1'b0;
      forever begin
         stall_len = pick_gap();
         open_len  = ($urandom_range(0, 15) == 0) ? 40 : $urandom_range(1, 8);
         if (stall_len > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (stall_len - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         repeat (open_len - 1) @(negedge clock);
      end
   end

   // reset values: b0 of 1.0 passes samples unchanged
   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample('1);
      wait_idle();
   endtask

   // largest and smallest gains drive the output into both limits
   task automatic test_saturation();
      write_register(CSR_COEF_B0, COEF_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd1);
      wait_idle();
      write_register(CSR_COEF_B0, COEF_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      wait_idle();
   endtask

   // all taps in use, feedback saturates and the limited value feeds back
   task automatic test_feedback_history();
      write_coefs(COEF_ONE, COEF_HALF, -COEF_HALF, -COEF_ONE, COEF_HALF);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd3);
      wait_idle();
   endtask

   // disabled filter passes items through and keeps its history
   task automatic test_disabled_passthrough();
      write_register(CSR_FILTER_ENABLE, 32'hFFFF_FFFE);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(24'sh12_3456);
      wait_idle();
      // writes to unused indexes have no effect
      write_register(CSR_SPARE_LO, '0);
      write_register(CSR_SPARE_HI, '1);
      write_register(CSR_FILTER_ENABLE, 32'hFFFF_FFFF);
      send_sample(24'sd100);
      send_sample(-24'sd100);
      send_sample('0);
      wait_idle();
   endtask

   // random coefficient sets, two of them at the extremes
   task automatic test_random_filters();
      bit full_range;
      for (int phase = 0; phase < 8; phase++) begin
         full_range = (phase % 3 == 2);
         case (phase)
            0: write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
            1: write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
            default: write_coefs(random_coef(full_range), random_coef(full_range),
                                 random_coef(full_range), random_coef(full_range),
                                 random_coef(full_range));
         endcase
         write_register(CSR_FILTER_ENABLE,
                        ($urandom_range(0, 5) == 0) ? 32'h0 : ($urandom() | 32'h1));
         repeat (100) send_sample(random_sample());
         wait_idle();
      end
   endtask

   initial begin
      mismatch_count   = 0;
      quiet_items      = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_in    = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_COEF_B0;
      csr_write_data   = '0;
      model_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_saturation();
      test_feedback_history();
      test_disabled_passthrough();
      test_random_filters();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
